// ===== design/tsz_pkg.sv =====
// Package for the texture surface size block: field widths, format classes and decode.
`timescale 1ns / 1ps
`default_nettype none

package tsz_pkg;

    // Field widths
    localparam int DIM_W   = 15;
    localparam int CODE_W  = 8;
    localparam int PITCH_W = 19;
    localparam int ROWS_W  = 15;
    localparam int BYTES_W = 33;

    // Default largest width or height taken as is
    localparam int MAX_DIMENSION_DEFAULT = 16384;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_DATA_W  = ((2 * DIM_W + CODE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((PITCH_W + ROWS_W + BYTES_W + 7) / 8) * 8;

    // Layout class of a format code
    typedef enum logic [3:0] {
        FMT_NONE   = 4'd0,
        FMT_BC8    = 4'd1,
        FMT_BC16   = 4'd2,
        FMT_PACKED = 4'd3,
        FMT_B1     = 4'd4,
        FMT_B8     = 4'd5,
        FMT_B16    = 4'd6,
        FMT_B32    = 4'd7,
        FMT_B64    = 4'd8,
        FMT_B96    = 4'd9,
        FMT_B128   = 4'd10
    } fmt_class_t;

    // Map a DXGI format code to its layout class
    function automatic fmt_class_t fmt_decode(input logic [CODE_W-1:0] code);
        fmt_class_t cls;
        cls = FMT_NONE;
        priority if ((code >= 8'd70 && code <= 8'd72) || (code >= 8'd79 && code <= 8'd81))
            cls = FMT_BC8;
        else if ((code >= 8'd73 && code <= 8'd78) || (code >= 8'd82 && code <= 8'd84) ||
                 (code >= 8'd94 && code <= 8'd99))
            cls = FMT_BC16;
        else if (code == 8'd68 || code == 8'd69)
            cls = FMT_PACKED;
        else if (code >= 8'd1 && code <= 8'd4)
            cls = FMT_B128;
        else if (code >= 8'd5 && code <= 8'd8)
            cls = FMT_B96;
        else if (code >= 8'd9 && code <= 8'd22)
            cls = FMT_B64;
        else if ((code >= 8'd23 && code <= 8'd47) || code == 8'd67 ||
                 (code >= 8'd87 && code <= 8'd93))
            cls = FMT_B32;
        else if ((code >= 8'd48 && code <= 8'd59) || code == 8'd85 || code == 8'd86 ||
                 code == 8'd115)
            cls = FMT_B16;
        else if (code >= 8'd60 && code <= 8'd65)
            cls = FMT_B8;
        else if (code == 8'd66)
            cls = FMT_B1;
        else
            cls = FMT_NONE;
        return cls;
    endfunction

endpackage

`default_nettype wire

// ===== design/texture_surface_size.sv =====
// Top level of the texture surface size block: four-stage pitch, row and size pipeline.
//
// Usage: one input transaction on s_axis carries a surface width, height and DXGI
// format code; one output transaction on m_axis returns the row pitch in bytes, the
// number of pixel or block rows and the total byte size (33 bits, no wrap).
// Block-compressed formats count 4x4 blocks of 8 or 16 bytes, the two packed 4:2:2
// formats use 4 bytes per pixel pair, other formats round each row up to whole bytes,
// unknown formats give zero bytes. Width and height above MAX_DIMENSION are clamped.
// Pipeline: four register stages; an accepted input is registered in stage 1 and moves
// on to stage 4. Stage 1 clamps and decodes the format, stage 2 forms pitch and
// rows, stage 3 multiplies (19 x 15 bits), stage 4 saturates into the output register.
// Throughput: one transaction per cycle while m_axis_tready stays high (no stall).
// Reset: rst_n clears every stage valid bit; no output is pending afterwards.
// Stall: when m_axis_tready is low, stages fill up behind the output register and
// s_axis_tready drops only once all four stages hold data; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module texture_surface_size #(
    parameter int MAX_DIMENSION = tsz_pkg::MAX_DIMENSION_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [14:0] surface_width, [29:15] surface_height, [37:30] format_code, rest zero
    input  wire logic [tsz_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [18:0] row_pitch_bytes, [33:19] row_total, [66:34] surface_bytes, rest zero
    output logic [tsz_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);

    localparam int DW = tsz_pkg::DIM_W;
    localparam int PW = tsz_pkg::PITCH_W;
    localparam int RW = tsz_pkg::ROWS_W;
    localparam int BW = tsz_pkg::BYTES_W;
    // Raw pitch can reach 16 bytes per pixel of the widest input
    localparam int RAW_PW = DW + 5;
    localparam int PROD_W = PW + RW;
    localparam int DIM_MAX_IN = (1 << DW) - 1;
    localparam logic [DW-1:0] DIM_CAP =
        DW'((MAX_DIMENSION > DIM_MAX_IN) ? DIM_MAX_IN : MAX_DIMENSION);

    // Input field split
    logic [DW-1:0]                width_in;
    logic [DW-1:0]                height_in;
    logic [tsz_pkg::CODE_W-1:0]   code_in;

    assign width_in  = s_axis_tdata[DW-1:0];
    assign height_in = s_axis_tdata[2*DW-1:DW];
    assign code_in   = s_axis_tdata[2*DW+tsz_pkg::CODE_W-1:2*DW];

    // Stage registers
    logic                         v1_reg, v2_reg, v3_reg, v4_reg;
    logic [DW-1:0]                w1_reg, h1_reg;
    tsz_pkg::fmt_class_t          cls1_reg;
    logic [PW-1:0]                pitch2_reg;
    logic [RW-1:0]                rows2_reg;
    logic [PW-1:0]                pitch3_reg;
    logic [RW-1:0]                rows3_reg;
    logic [PROD_W-1:0]            prod3_reg;
    logic [PW-1:0]                pitch4_reg;
    logic [RW-1:0]                rows4_reg;
    logic [BW-1:0]                bytes4_reg;

    // Backpressure chain: a stage advances when empty or when the next one advances
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || m_axis_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_axis_tready = rdy1;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_axis_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: clamp and decode
    always_ff @(posedge clk)
    begin
        if (rdy1 && s_axis_tvalid)
        begin
            w1_reg   <= (width_in > DIM_CAP) ? DIM_CAP : width_in;
            h1_reg   <= (height_in > DIM_CAP) ? DIM_CAP : height_in;
            cls1_reg <= tsz_pkg::fmt_decode(code_in);
        end
    end

    // Stage 2: pitch and row count
    logic [DW:0]       w_ext, h_ext;
    logic [DW:0]       blk_w, blk_h, pair_w, byte_w;
    logic [RAW_PW-1:0] pitch_raw;
    logic [DW:0]       rows_raw;
    logic              bc_fmt;

    always_comb
    begin
        w_ext  = {1'b0, w1_reg};
        h_ext  = {1'b0, h1_reg};
        blk_w  = (w_ext + (DW+1)'(3)) >> 2;
        blk_h  = (h_ext + (DW+1)'(3)) >> 2;
        pair_w = (w_ext + (DW+1)'(1)) >> 1;
        byte_w = (w_ext + (DW+1)'(7)) >> 3;
        bc_fmt = (cls1_reg == tsz_pkg::FMT_BC8) || (cls1_reg == tsz_pkg::FMT_BC16);
        unique case (cls1_reg)
            tsz_pkg::FMT_BC8:    pitch_raw = RAW_PW'({blk_w, 3'b000});
            tsz_pkg::FMT_BC16:   pitch_raw = RAW_PW'({blk_w, 4'b0000});
            tsz_pkg::FMT_PACKED: pitch_raw = RAW_PW'({pair_w, 2'b00});
            tsz_pkg::FMT_B1:     pitch_raw = RAW_PW'(byte_w);
            tsz_pkg::FMT_B8:     pitch_raw = RAW_PW'(w_ext);
            tsz_pkg::FMT_B16:    pitch_raw = RAW_PW'({w_ext, 1'b0});
            tsz_pkg::FMT_B32:    pitch_raw = RAW_PW'({w_ext, 2'b00});
            tsz_pkg::FMT_B64:    pitch_raw = RAW_PW'({w_ext, 3'b000});
            tsz_pkg::FMT_B96:    pitch_raw = RAW_PW'({w_ext, 3'b000}) +
                                             RAW_PW'({w_ext, 2'b00});
            tsz_pkg::FMT_B128:   pitch_raw = RAW_PW'({w_ext, 4'b0000});
            default:             pitch_raw = '0;
        endcase
        rows_raw = bc_fmt ? blk_h : h_ext;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            pitch2_reg <= (pitch_raw > RAW_PW'({PW{1'b1}})) ? {PW{1'b1}} : pitch_raw[PW-1:0];
            rows2_reg  <= (rows_raw > (DW+1)'({RW{1'b1}})) ? {RW{1'b1}} : rows_raw[RW-1:0];
        end
    end

    // Stage 3: total byte product
    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            pitch3_reg <= pitch2_reg;
            rows3_reg  <= rows2_reg;
            prod3_reg  <= PROD_W'(pitch2_reg) * PROD_W'(rows2_reg);
        end
    end

    // Stage 4: saturate total into the output register
    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            pitch4_reg <= pitch3_reg;
            rows4_reg  <= rows3_reg;
            bytes4_reg <= (prod3_reg > PROD_W'({BW{1'b1}})) ? {BW{1'b1}} : prod3_reg[BW-1:0];
        end
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = tsz_pkg::OUT_DATA_W'({bytes4_reg, rows4_reg, pitch4_reg});

    // Checks
    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted transaction did not reach stage 1");

    a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !rdy2 |=> v1_reg && $stable(w1_reg) && $stable(cls1_reg))
        else $error("stage 1 changed while stalled");

    a_zero_pitch_zero_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && (pitch4_reg == '0) |-> (bytes4_reg == '0))
        else $error("zero pitch with non-zero total");

    a_rows_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (rows4_reg <= RW'(DIM_CAP)))
        else $error("row count above clamp limit");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for texture_surface_size: directed and random surfaces checked against a local layout predictor.
`timescale 1ns / 1ps

module tb;

    // DXGI format codes used by the layout predictor and the directed cases
    localparam logic [7:0] F_UNKNOWN              = 8'd0;
    localparam logic [7:0] F_R32G32B32A32_TYPELESS = 8'd1;
    localparam logic [7:0] F_R32G32B32A32_SINT    = 8'd4;
    localparam logic [7:0] F_R32G32B32_TYPELESS   = 8'd5;
    localparam logic [7:0] F_R32G32B32_SINT       = 8'd8;
    localparam logic [7:0] F_R16G16B16A16_TYPELESS = 8'd9;
    localparam logic [7:0] F_X32_G8X24_UINT       = 8'd22;
    localparam logic [7:0] F_R10G10B10A2_TYPELESS = 8'd23;
    localparam logic [7:0] F_X24_G8_UINT          = 8'd47;
    localparam logic [7:0] F_R8G8_TYPELESS        = 8'd48;
    localparam logic [7:0] F_R16_SINT             = 8'd59;
    localparam logic [7:0] F_R8_TYPELESS          = 8'd60;
    localparam logic [7:0] F_A8_UNORM             = 8'd65;
    localparam logic [7:0] F_R1_UNORM             = 8'd66;
    localparam logic [7:0] F_R9G9B9E5_SHAREDEXP   = 8'd67;
    localparam logic [7:0] F_R8G8_B8G8_UNORM      = 8'd68;
    localparam logic [7:0] F_G8R8_G8B8_UNORM      = 8'd69;
    localparam logic [7:0] F_BC1_TYPELESS         = 8'd70;
    localparam logic [7:0] F_BC1_UNORM_SRGB       = 8'd72;
    localparam logic [7:0] F_BC2_TYPELESS         = 8'd73;
    localparam logic [7:0] F_BC3_UNORM_SRGB       = 8'd78;
    localparam logic [7:0] F_BC3_UNORM            = 8'd77;
    localparam logic [7:0] F_BC4_TYPELESS         = 8'd79;
    localparam logic [7:0] F_BC4_SNORM            = 8'd81;
    localparam logic [7:0] F_BC5_TYPELESS         = 8'd82;
    localparam logic [7:0] F_BC5_SNORM            = 8'd84;
    localparam logic [7:0] F_B5G6R5_UNORM         = 8'd85;
    localparam logic [7:0] F_B5G5R5A1_UNORM       = 8'd86;
    localparam logic [7:0] F_B8G8R8A8_UNORM       = 8'd87;
    localparam logic [7:0] F_B8G8R8X8_UNORM_SRGB  = 8'd93;
    localparam logic [7:0] F_BC6H_TYPELESS        = 8'd94;
    localparam logic [7:0] F_BC7_UNORM_SRGB       = 8'd99;
    localparam logic [7:0] F_AYUV                 = 8'd100;
    localparam logic [7:0] F_B4G4R4A4_UNORM       = 8'd115;
    localparam logic [7:0] F_CODE_TOP             = 8'd255;

    localparam longint unsigned DIM_LIMIT  = tsz_pkg::MAX_DIMENSION_DEFAULT;
    localparam longint unsigned PITCH_TOP  = (64'd1 << tsz_pkg::PITCH_W) - 1;
    localparam longint unsigned ROWS_TOP   = (64'd1 << tsz_pkg::ROWS_W) - 1;
    localparam longint unsigned BYTES_TOP  = (64'd1 << tsz_pkg::BYTES_W) - 1;
    localparam int              STALL_LIMIT = 2000;
    localparam int              HOLDOFF_CYCLES = 120;
    localparam int              DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [tsz_pkg::PITCH_W-1:0] pitch;
        logic [tsz_pkg::ROWS_W-1:0]  rows;
        logic [tsz_pkg::BYTES_W-1:0] bytes;
    } surface_layout_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [tsz_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [tsz_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    surface_layout_t pending_layouts[$];
    int              error_count = 0;
    int              surfaces_sent = 0;
    int              layouts_checked = 0;
    int              quiet_cycles = 0;

    // sender gaps are owned by the stimulus process; receiver controls by NBA
    bit              tx_gaps = 1'b1;
    bit              rx_steady = 1'b0;
    int unsigned     holdoff_req = 0;
    int unsigned     holdoff_seen = 0;
    int              holdoff_left = 0;

    texture_surface_size dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // bits per pixel of plain formats, 0 when the code is not one
    function automatic int unsigned pixel_bits(input logic [7:0] code);
        if (code >= F_R32G32B32A32_TYPELESS && code <= F_R32G32B32A32_SINT) return 128;
        if (code >= F_R32G32B32_TYPELESS && code <= F_R32G32B32_SINT) return 96;
        if (code >= F_R16G16B16A16_TYPELESS && code <= F_X32_G8X24_UINT) return 64;
        if (code >= F_R10G10B10A2_TYPELESS && code <= F_X24_G8_UINT) return 32;
        if (code >= F_R8G8_TYPELESS && code <= F_R16_SINT) return 16;
        if (code >= F_R8_TYPELESS && code <= F_A8_UNORM) return 8;
        if (code == F_R1_UNORM) return 1;
        if (code == F_R9G9B9E5_SHAREDEXP) return 32;
        if (code == F_B5G6R5_UNORM || code == F_B5G5R5A1_UNORM) return 16;
        if (code >= F_B8G8R8A8_UNORM && code <= F_B8G8R8X8_UNORM_SRGB) return 32;
        if (code == F_B4G4R4A4_UNORM) return 16;
        return 0;
    endfunction

    // bytes per 4x4 block of compressed formats, 0 when not compressed
    function automatic int unsigned block_bytes(input logic [7:0] code);
        if ((code >= F_BC1_TYPELESS && code <= F_BC1_UNORM_SRGB) ||
            (code >= F_BC4_TYPELESS && code <= F_BC4_SNORM))
            return 8;
        if ((code >= F_BC2_TYPELESS && code <= F_BC3_UNORM_SRGB) ||
            (code >= F_BC5_TYPELESS && code <= F_BC5_SNORM) ||
            (code >= F_BC6H_TYPELESS && code <= F_BC7_UNORM_SRGB))
            return 16;
        return 0;
    endfunction

    function automatic longint unsigned clip(input longint unsigned v,
                                             input longint unsigned top);
        return (v > top) ? top : v;
    endfunction

    // layout of one surface: pitch, row count and total bytes
    function automatic surface_layout_t surface_layout(input logic [14:0] width,
                                                       input logic [14:0] height,
                                                       input logic [7:0]  code);
        longint unsigned w;
        longint unsigned h;
        longint unsigned pitch;
        longint unsigned rows;
        longint unsigned total;
        int unsigned     blk;
        surface_layout_t lay;
        w = (width > DIM_LIMIT) ? DIM_LIMIT : width;
        h = (height > DIM_LIMIT) ? DIM_LIMIT : height;
        blk = block_bytes(code);
        if (blk != 0)
        begin
            pitch = ((w + 3) / 4) * blk;
            rows = (h + 3) / 4;
        end
        else if (code == F_R8G8_B8G8_UNORM || code == F_G8R8_G8B8_UNORM)
        begin
            pitch = ((w + 1) >> 1) * 4;
            rows = h;
        end
        else
        begin
            pitch = (w * pixel_bits(code) + 7) / 8;
            rows = h;
        end
        pitch = clip(pitch, PITCH_TOP);
        rows = clip(rows, ROWS_TOP);
        total = clip(pitch * rows, BYTES_TOP);
        lay.pitch = pitch[tsz_pkg::PITCH_W-1:0];
        lay.rows = rows[tsz_pkg::ROWS_W-1:0];
        lay.bytes = total[tsz_pkg::BYTES_W-1:0];
        return lay;
    endfunction

    // offer one surface and wait for its transaction; valid stays high for a follow-on item
    task automatic send_surface(input logic [14:0] width, input logic [14:0] height,
                                input logic [7:0] code);
        if (tx_gaps)
        begin
            while ($urandom_range(0, 99) < 29)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, code, height, width};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_layouts.push_back(surface_layout(width, height, code));
        surfaces_sent++;
    endtask

    // dimension mix: mostly moderate, with zero, the clamp edge and the full field
    function automatic logic [14:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 15'($urandom_range(0, 32767));
            1: return 15'($urandom_range(32'(DIM_LIMIT - 4), 32'(DIM_LIMIT + 4)));
            2: return 15'($urandom_range(0, 9));
            3: return 15'($urandom_range(0, 16384));
            default: return 15'($urandom_range(0, 2048));
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 3) return 8'($urandom_range(0, 255));
        if (sel == 9) return F_B4G4R4A4_UNORM;
        return 8'($urandom_range(F_UNKNOWN, F_BC7_UNORM_SRGB));
    endfunction

    task automatic send_random_surface();
        send_surface(pick_dim(), pick_dim(), pick_code());
    endtask

    // extremes of each field and one or more cases per format class
    task automatic test_directed();
        send_surface(15'd0, 15'd0, F_R32G32B32A32_TYPELESS);
        send_surface(15'd16384, 15'd16384, F_R32G32B32A32_TYPELESS);
        send_surface(15'h7FFF, 15'h7FFF, F_R32G32B32A32_SINT);
        send_surface(15'd1, 15'd1, F_R32G32B32_TYPELESS);
        send_surface(15'd3, 15'd5, F_R16G16B16A16_TYPELESS);
        send_surface(15'd7, 15'd2, F_R10G10B10A2_TYPELESS);
        send_surface(15'd9, 15'd1, F_R8G8_TYPELESS);
        send_surface(15'd13, 15'd3, F_R8_TYPELESS);
        send_surface(15'd9, 15'd4, F_R1_UNORM);
        send_surface(15'd16384, 15'd1, F_R1_UNORM);
        send_surface(15'd5, 15'd1, F_R9G9B9E5_SHAREDEXP);
        send_surface(15'd1, 15'd1, F_R8G8_B8G8_UNORM);
        send_surface(15'd3, 15'd7, F_G8R8_G8B8_UNORM);
        send_surface(15'd1, 15'd1, F_BC1_TYPELESS);
        send_surface(15'd5, 15'd5, F_BC4_SNORM);
        send_surface(15'd0, 15'd4, F_BC1_UNORM_SRGB);
        send_surface(15'd4, 15'd0, F_BC3_UNORM);
        send_surface(15'd16384, 15'd16384, F_BC7_UNORM_SRGB);
        send_surface(15'h7FFF, 15'd1, F_BC5_TYPELESS);
        send_surface(15'd17, 15'd17, F_B5G6R5_UNORM);
        send_surface(15'd11, 15'd2, F_B8G8R8A8_UNORM);
        send_surface(15'd10, 15'd10, F_B4G4R4A4_UNORM);
        send_surface(15'd100, 15'd100, F_UNKNOWN);
        send_surface(15'd33, 15'd2, F_CODE_TOP);
        send_surface(15'd64, 15'd64, F_AYUV);
    endtask

    // every format code once with random dimensions
    task automatic test_format_sweep();
        int code;
        for (code = 0; code < 256; code++)
            send_surface(pick_dim(), pick_dim(), code[7:0]);
    endtask

    task automatic test_random_traffic(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_random_surface();
    endtask

    // back-to-back stream with both sides always ready
    task automatic test_steady_stream(input int count);
        int i;
        tx_gaps = 1'b0;
        rx_steady <= 1'b1;
        for (i = 0; i < count; i++)
            send_random_surface();
        rx_steady <= 1'b0;
        tx_gaps = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, so the pipeline fills
    task automatic test_output_backpressure(input int count);
        int i;
        tx_gaps = 1'b0;
        holdoff_req <= holdoff_req + 1;
        for (i = 0; i < count; i++)
            send_random_surface();
        tx_gaps = 1'b1;
    endtask

    // receiver ready: random idling, steady stretches and the long hold-off
    always @(posedge clk)
    begin
        if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (holdoff_req != holdoff_seen)
        begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (rx_steady)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= 29);
    end

    // compare each output transaction with the oldest predicted layout
    always @(posedge clk)
    begin : check_layout
        surface_layout_t want;
        surface_layout_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.pitch = m_axis_tdata[18:0];
            got.rows = m_axis_tdata[33:19];
            got.bytes = m_axis_tdata[66:34];
            if (pending_layouts.size() == 0)
            begin
                $error("unexpected layout: pitch %0d rows %0d bytes %0d",
                       got.pitch, got.rows, got.bytes);
                error_count++;
            end
            else
            begin
                want = pending_layouts.pop_front();
                layouts_checked++;
                if (got.pitch !== want.pitch)
                begin
                    $error("row_pitch_bytes: expected %0d, actual %0d", want.pitch, got.pitch);
                    error_count++;
                end
                if (got.rows !== want.rows)
                begin
                    $error("row_total: expected %0d, actual %0d", want.rows, got.rows);
                    error_count++;
                end
                if (got.bytes !== want.bytes)
                begin
                    $error("surface_bytes: expected %0d, actual %0d", want.bytes, got.bytes);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d layouts pending",
                     quiet_cycles, pending_layouts.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_format_sweep();
        test_random_traffic(500);
        test_steady_stream(400);
        test_output_backpressure(120);
        test_random_traffic(400);

        s_axis_tvalid <= 1'b0;
        while (pending_layouts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d surfaces sent, %0d layouts checked, %0d mismatches",
                 surfaces_sent, layouts_checked, error_count);
        $display("summary: all 256 format codes, clamped and zero sizes, idle and stall phases");
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
